### rtl/core/phong_light_shader_defines.svh
// Assertion macros for the Phong lighting shader.
`ifndef PHONG_LIGHT_SHADER_DEFINES_SVH
`define PHONG_LIGHT_SHADER_DEFINES_SVH

// Check an expression at every clock edge out of reset.
`define PLS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that an antecedent implies a consequent at the same clock edge.
`define PLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/pls_pkg.sv
// Types, constants and arithmetic helpers shared by the Phong lighting shader.
package pls_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int FRACTION_BITS  = 14;
  localparam int EXPONENT_BITS  = 8;

  localparam int VEC_W  = 3 * COMPONENT_BITS;
  localparam int PROD_W = 2 * COMPONENT_BITS;
  localparam int P_W    = 2 * COMPONENT_BITS - FRACTION_BITS;
  localparam int DOT_W  = 2 * COMPONENT_BITS + 2;

  localparam int PIPE_DEPTH = 4 + 2 * EXPONENT_BITS;

  localparam logic [COMPONENT_BITS-1:0] MAX_COMP = {COMPONENT_BITS{1'b1}};
  localparam logic [COMPONENT_BITS-1:0] ONE_COMP =
    {{(COMPONENT_BITS-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};

  typedef struct packed {
    logic [VEC_W-1:0]         surface_normal;
    logic [VEC_W-1:0]         light_dir;
    logic [VEC_W-1:0]         reflect_dir;
    logic [VEC_W-1:0]         view_dir;
    logic [VEC_W-1:0]         diffuse_coef;
    logic [VEC_W-1:0]         specular_coef;
    logic [VEC_W-1:0]         light_color;
    logic [EXPONENT_BITS-1:0] shininess;
  } in_item_t;

  typedef struct packed {
    logic [VEC_W-1:0] diffuse_color;
    logic [VEC_W-1:0] specular_color;
  } out_item_t;

  typedef struct packed {
    logic                     spec_ok;
    logic [EXPONENT_BITS-1:0] ns;
    logic [COMPONENT_BITS-1:0] base;
    logic [2:0][P_W-1:0]      p_spec;
    logic [VEC_W-1:0]         diffuse;
  } pow_side_t;

  typedef struct packed {
    logic                      valid;
    logic [COMPONENT_BITS-1:0] acc;
    pow_side_t                 side;
  } pow_bus_t;

  function automatic logic [COMPONENT_BITS-1:0] mul_shift_sat(
    input logic [P_W-1:0]            a,
    input logic [COMPONENT_BITS-1:0] b
  );
    logic [P_W+COMPONENT_BITS-1:0]               prod;
    logic [P_W+COMPONENT_BITS-FRACTION_BITS-1:0] q;
    prod = {{COMPONENT_BITS{1'b0}}, a} * {{P_W{1'b0}}, b};
    q    = prod[P_W+COMPONENT_BITS-1:FRACTION_BITS];
    return (|q[P_W+COMPONENT_BITS-FRACTION_BITS-1:COMPONENT_BITS]) ?
           MAX_COMP : q[COMPONENT_BITS-1:0];
  endfunction

  function automatic logic [COMPONENT_BITS-1:0] dot_factor(input logic [DOT_W-1:0] d);
    logic [DOT_W-2-FRACTION_BITS:0] q;
    q = d[DOT_W-2:FRACTION_BITS];
    return (|q[DOT_W-2-FRACTION_BITS:COMPONENT_BITS]) ? MAX_COMP : q[COMPONENT_BITS-1:0];
  endfunction

endpackage

### rtl/core/pls_front.sv
// Front stages of the shader: dot products, dot factors and the diffuse term.
module pls_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  pls_pkg::in_item_t in_item,
  output pls_pkg::pow_bus_t bus_out
);
  import pls_pkg::*;

  logic                     s1_valid_r;
  logic [2:0][PROD_W-1:0]   s1_nl_r, s1_nl_nxt;
  logic [2:0][PROD_W-1:0]   s1_vr_r, s1_vr_nxt;
  logic [2:0][P_W-1:0]      s1_pd_r, s1_pd_nxt;
  logic [2:0][P_W-1:0]      s1_ps_r, s1_ps_nxt;
  logic [EXPONENT_BITS-1:0] s1_ns_r;

  logic                      s2_valid_r;
  logic                      s2_nl_pos_r, s2_nl_pos_nxt;
  logic                      s2_vr_pos_r, s2_vr_pos_nxt;
  logic [COMPONENT_BITS-1:0] s2_fd_r, s2_fd_nxt;
  logic [COMPONENT_BITS-1:0] s2_fv_r, s2_fv_nxt;
  logic [2:0][P_W-1:0]       s2_pd_r;
  logic [2:0][P_W-1:0]       s2_ps_r;
  logic [EXPONENT_BITS-1:0]  s2_ns_r;
  logic [DOT_W-1:0]          dot_nl, dot_vr;

  logic      s3_valid_r;
  pow_side_t s3_side_r, s3_side_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_nl_nxt[i] = PROD_W'(
        $signed(in_item.surface_normal[i*COMPONENT_BITS +: COMPONENT_BITS]) *
        $signed(in_item.light_dir[i*COMPONENT_BITS +: COMPONENT_BITS]));
      s1_vr_nxt[i] = PROD_W'(
        $signed(in_item.view_dir[i*COMPONENT_BITS +: COMPONENT_BITS]) *
        $signed(in_item.reflect_dir[i*COMPONENT_BITS +: COMPONENT_BITS]));
      s1_pd_nxt[i] = P_W'((
        {{COMPONENT_BITS{1'b0}}, in_item.diffuse_coef[i*COMPONENT_BITS +: COMPONENT_BITS]} *
        {{COMPONENT_BITS{1'b0}}, in_item.light_color[i*COMPONENT_BITS +: COMPONENT_BITS]})
        >> FRACTION_BITS);
      s1_ps_nxt[i] = P_W'((
        {{COMPONENT_BITS{1'b0}}, in_item.specular_coef[i*COMPONENT_BITS +: COMPONENT_BITS]} *
        {{COMPONENT_BITS{1'b0}}, in_item.light_color[i*COMPONENT_BITS +: COMPONENT_BITS]})
        >> FRACTION_BITS);
    end
  end

  always_comb begin
    dot_nl = DOT_W'($signed(s1_nl_r[0])) + DOT_W'($signed(s1_nl_r[1])) +
             DOT_W'($signed(s1_nl_r[2]));
    dot_vr = DOT_W'($signed(s1_vr_r[0])) + DOT_W'($signed(s1_vr_r[1])) +
             DOT_W'($signed(s1_vr_r[2]));
    s2_nl_pos_nxt = !dot_nl[DOT_W-1] && (dot_nl != '0);
    s2_vr_pos_nxt = !dot_vr[DOT_W-1] && (dot_vr != '0);
    s2_fd_nxt     = dot_factor(dot_nl);
    s2_fv_nxt     = dot_factor(dot_vr);
  end

  always_comb begin
    s3_side_nxt.spec_ok = s2_nl_pos_r && s2_vr_pos_r;
    s3_side_nxt.ns      = s2_ns_r;
    s3_side_nxt.base    = s2_fv_r;
    s3_side_nxt.p_spec  = s2_ps_r;
    for (int i = 0; i < 3; i++) begin
      s3_side_nxt.diffuse[i*COMPONENT_BITS +: COMPONENT_BITS] =
        s2_nl_pos_r ? mul_shift_sat(s2_pd_r[i], s2_fd_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_nl_r     <= s1_nl_nxt;
    s1_vr_r     <= s1_vr_nxt;
    s1_pd_r     <= s1_pd_nxt;
    s1_ps_r     <= s1_ps_nxt;
    s1_ns_r     <= in_item.shininess;
    s2_nl_pos_r <= s2_nl_pos_nxt;
    s2_vr_pos_r <= s2_vr_pos_nxt;
    s2_fd_r     <= s2_fd_nxt;
    s2_fv_r     <= s2_fv_nxt;
    s2_pd_r     <= s1_pd_r;
    s2_ps_r     <= s1_ps_r;
    s2_ns_r     <= s1_ns_r;
    s3_side_r   <= s3_side_nxt;
  end

  assign bus_out.valid = s3_valid_r;
  assign bus_out.acc   = ONE_COMP;
  assign bus_out.side  = s3_side_r;

endmodule

### rtl/core/pls_pow_step.sv
// One stage of the square-and-multiply power chain.
module pls_pow_step (
  input  logic              clk,
  input  logic              rst_n,
  input  pls_pkg::pow_bus_t bus_in,
  input  logic              mult_sel,
  input  logic              apply,
  output pls_pkg::pow_bus_t bus_out
);
  import pls_pkg::*;

  logic                      valid_r;
  logic [COMPONENT_BITS-1:0] acc_r, acc_nxt;
  logic [COMPONENT_BITS-1:0] operand;
  pow_side_t                 side_r;

  always_comb begin
    operand = mult_sel ? bus_in.side.base : bus_in.acc;
    acc_nxt = apply ? mul_shift_sat(P_W'(bus_in.acc), operand) : bus_in.acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= bus_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    side_r <= bus_in.side;
  end

  assign bus_out.valid = valid_r;
  assign bus_out.acc   = acc_r;
  assign bus_out.side  = side_r;

endmodule

### rtl/core/pls_shade.sv
// Final stage of the shader: specular scaling and the result register.
module pls_shade (
  input  logic               clk,
  input  logic               rst_n,
  input  pls_pkg::pow_bus_t  bus_in,
  output logic               out_strobe,
  output pls_pkg::out_item_t out_item
);
  import pls_pkg::*;

  logic      strobe_r;
  out_item_t item_r, item_nxt;

  always_comb begin
    item_nxt.diffuse_color = bus_in.side.diffuse;
    for (int i = 0; i < 3; i++) begin
      item_nxt.specular_color[i*COMPONENT_BITS +: COMPONENT_BITS] =
        bus_in.side.spec_ok ? mul_shift_sat(bus_in.side.p_spec[i], bus_in.acc) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= bus_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule

### rtl/core/phong_light_shader.sv
// Top level of the Phong diffuse and specular lighting shader.
// The shader takes one item in every clock cycle and never stalls: busy is
// always low, so an item is accepted at every edge where start is high. Each
// item's result appears on out_item, marked by a one-cycle out_strobe, in the
// order the items came in. The pipeline is three front stages (products, dot
// sums, diffuse scaling), two multiplier stages for each of the eight
// shininess bits in the square-and-multiply chain, and the output register.
module phong_light_shader (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pls_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output pls_pkg::out_item_t out_item
);
  import pls_pkg::*;

  pow_bus_t chain [2*EXPONENT_BITS+1];

  assign busy = 1'b0;

  pls_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_item  (in_item),
    .bus_out  (chain[0])
  );

  for (genvar k = 0; k < EXPONENT_BITS; k++) begin : g_pow
    pls_pow_step u_square (
      .clk      (clk),
      .rst_n    (rst_n),
      .bus_in   (chain[2*k]),
      .mult_sel (1'b0),
      .apply    (1'b1),
      .bus_out  (chain[2*k+1])
    );

    pls_pow_step u_mult (
      .clk      (clk),
      .rst_n    (rst_n),
      .bus_in   (chain[2*k+1]),
      .mult_sel (1'b1),
      .apply    (chain[2*k+1].side.ns[EXPONENT_BITS-1-k]),
      .bus_out  (chain[2*k+2])
    );
  end

  pls_shade u_shade (
    .clk        (clk),
    .rst_n      (rst_n),
    .bus_in     (chain[2*EXPONENT_BITS]),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

### rtl/core/pls_port_monitor.sv
// Port-level assertions for the Phong lighting shader and their bind.
`include "phong_light_shader_defines.svh"

module pls_port_monitor (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input pls_pkg::in_item_t  in_item,
  input logic               out_strobe,
  input pls_pkg::out_item_t out_item
);
  import pls_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic [CNT_W-1:0] up_cnt_r;
  logic             settled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_cnt_r <= '0;
    end else if (up_cnt_r != CNT_W'(PIPE_DEPTH)) begin
      up_cnt_r <= up_cnt_r + 1'b1;
    end
  end

  assign settled = (up_cnt_r == CNT_W'(PIPE_DEPTH));

  `PLS_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy raised")

  `PLS_ASSERT_IMPLY(a_strobe_latency, clk, rst_n, settled, out_strobe == $past(start && !busy, PIPE_DEPTH), "strobe does not follow accepted item")

  `PLS_ASSERT_IMPLY(a_dark_light, clk, rst_n, settled && $past(start && !busy && (in_item.light_color == '0), PIPE_DEPTH), (out_item.diffuse_color == '0) && (out_item.specular_color == '0), "zero light gave color")

  `PLS_ASSERT_IMPLY(a_zero_normal, clk, rst_n, settled && $past(start && !busy && (in_item.surface_normal == '0), PIPE_DEPTH), (out_item.diffuse_color == '0) && (out_item.specular_color == '0), "zero normal gave color")

endmodule

bind phong_light_shader pls_port_monitor u_port_monitor (.*);
